// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file stt_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
// Package for the software timer table: sizes, codes and the slot entry type.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

	localparam int SLOTS       = 16;
	localparam int HANDLE_BITS = 16;
	localparam int TIME_W      = 31;
	localparam int CNT_W       = $clog2(SLOTS + 1);

	localparam logic [2:0] FUNC_ONCE       = 3'd0;
	localparam logic [2:0] FUNC_REPEAT     = 3'd1;
	localparam logic [2:0] FUNC_CANCEL     = 3'd2;
	localparam logic [2:0] FUNC_CANCEL_ALL = 3'd3;
	localparam logic [2:0] FUNC_TICK       = 3'd4;

	typedef enum logic [1:0] {
		KIND_ACK,
		KIND_SCHED,
		KIND_FULL,
		KIND_FIRED
	} kind_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_SHIFT,
		C_CLEAR,
		C_CANCEL
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_TICK
	} state_t;

	typedef struct packed {
		logic                   used;
		logic                   active;
		logic                   rpt;
		logic [HANDLE_BITS-1:0] handle;
		logic [TIME_W-1:0]      remaining;
		logic [TIME_W-1:0]      interval;
	} entry_t;

	localparam entry_t ENTRY_EMPTY = '0;

endpackage

// ===== sv/stt_cell.sv =====
// One slot of the timer chain: holds an entry, shifts from its right neighbor,
// takes an inserted entry, and passes the cancel search flag on. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stt_pkg::cell_op_t               op,
	input  logic                            ins,
	input  stt_pkg::entry_t                 ins_entry,
	input  stt_pkg::entry_t                 nbr,
	input  logic [stt_pkg::HANDLE_BITS-1:0] cancel_handle,
	input  logic                            found_in,
	output logic                            found_out,
	output stt_pkg::entry_t                 ent
);
	import stt_pkg::*;

	logic                   used_q;
	logic                   active_q;
	logic                   rpt_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [TIME_W-1:0]      rem_q;
	logic [TIME_W-1:0]      ival_q;
	logic                   match;
	entry_t                 nxt;

	assign ent = '{used: used_q, active: active_q, rpt: rpt_q, handle: handle_q,
		remaining: rem_q, interval: ival_q};

	// first used entry with this handle wins
	assign match     = used_q && (handle_q == cancel_handle);
	assign found_out = found_in || match;

	always_comb begin
		nxt = ent;
		case (op)
			C_HOLD: begin
			end
			C_SHIFT: begin
				nxt = nbr;
			end
			C_CLEAR: begin
				nxt.used   = 1'b0;
				nxt.active = 1'b0;
			end
			C_CANCEL: begin
				if (match && !found_in) begin
					nxt.active = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (ins) begin
			nxt = ins_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			active_q <= 1'b0;
		end else begin
			used_q   <= nxt.used;
			active_q <= nxt.active;
		end
	end

	always_ff @(posedge clk) begin
		rpt_q    <= nxt.rpt;
		handle_q <= nxt.handle;
		rem_q    <= nxt.remaining;
		ival_q   <= nxt.interval;
	end

endmodule

// ===== sv/stt_proc.sv =====
// Tick update for the entry at the head of the chain: subtract the step,
// decide fire, reload repeating timers, decide whether it stays. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_proc (
	input  stt_pkg::entry_t                head,
	input  logic [stt_pkg::TIME_W-1:0]     step,
	output logic                           fire,
	output logic                           keep,
	output stt_pkg::entry_t                nxt
);
	import stt_pkg::*;

	logic signed [TIME_W:0]   diff;
	logic signed [TIME_W+1:0] sum;
	logic                     diff_np;
	logic                     sum_np;

	assign diff    = $signed({1'b0, head.remaining}) - $signed({1'b0, step});
	assign diff_np = diff[TIME_W] || (diff == '0);
	assign sum     = $signed({diff[TIME_W], diff}) + $signed({2'b00, head.interval});
	assign sum_np  = sum[TIME_W+1] || (sum == '0);

	assign fire = head.active && diff_np;
	assign keep = head.active && (!diff_np || head.rpt);

	always_comb begin
		nxt        = head;
		nxt.used   = 1'b1;
		nxt.active = 1'b1;
		if (!diff_np) begin
			nxt.remaining = diff[TIME_W-1:0];
		end else if (sum_np) begin
			nxt.remaining = head.interval;
		end else begin
			nxt.remaining = sum[TIME_W-1:0];
		end
	end

endmodule

// ===== sv/software_timer_table.sv =====
// Software timer table: schedule, cancel, cancel-all and tick over a chain of slot cells.
// Schedule, cancel, cancel-all and unknown requests show their one result in the cycle
// after acceptance. A tick walks the used slots through the head unit, one slot per cycle
// unless the output stalls, and marks its final result with last.
// Throughput: one item per cycle while results are taken; no item is taken during a tick.
// Reset (arst_n low, asynchronous): table empty, next handle 1, tick_step 1, no result pending.
`timescale 1ns / 1ps

module software_timer_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic signed [31:0]              delay,
	input  logic [stt_pkg::HANDLE_BITS-1:0] handle,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      kind,
	output logic [stt_pkg::HANDLE_BITS-1:0] timer_handle,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [stt_pkg::TIME_W-1:0]      cfg_data
);
	import stt_pkg::*;

	// Control and configuration registers
	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;      // occupied slots, always the low positions
	logic [CNT_W-1:0]       rem_q, rem_d;      // slots still to pass the head during a tick
	logic [HANDLE_BITS-1:0] next_handle_q, next_handle_d;
	logic [TIME_W-1:0]      tick_step_q;

	// A fired timer is held until the next fire or the tick's end so the last one can carry last
	logic                   pend_valid_q, pend_valid_d;
	logic [HANDLE_BITS-1:0] pend_handle_q, pend_handle_d;

	// Output register
	logic                   ovalid_q;
	kind_t                  okind_q, okind_d;
	logic [HANDLE_BITS-1:0] ohandle_q, ohandle_d;
	logic                   olast_q, olast_d;
	logic                   out_load;
	logic                   out_free;

	// Chain control
	cell_op_t               cell_op;
	logic                   ins_en;
	logic [CNT_W-1:0]       ins_pos;
	entry_t                 ins_entry;
	entry_t                 ent [SLOTS];
	logic [SLOTS:0]         fnd;

	// Head unit
	logic                   h_fire;
	logic                   h_keep;
	entry_t                 h_next;

	logic                   in_fire;
	logic                   sched_rpt;
	logic [TIME_W-1:0]      delay_clamped;
	logic [HANDLE_BITS-1:0] handle_inc;

	assign out_free  = !ovalid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid    = ovalid_q;
	assign kind         = okind_q;
	assign timer_handle = ohandle_q;
	assign last         = olast_q;

	// Negative delays clamp to zero; a one-shot timer keeps a zero interval
	assign sched_rpt     = (func == FUNC_REPEAT);
	assign delay_clamped = delay[31] ? '0 : delay[TIME_W-1:0];
	assign handle_inc    = next_handle_q + 1'b1;

	assign fnd[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			entry_t nbr_ent;
			logic   ins_here;

			if (gi == SLOTS - 1) begin : g_tail
				assign nbr_ent = ENTRY_EMPTY;
			end else begin : g_mid
				assign nbr_ent = ent[gi+1];
			end

			assign ins_here = ins_en && (ins_pos == CNT_W'(gi));

			stt_cell u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.op            (cell_op),
				.ins           (ins_here),
				.ins_entry     (ins_entry),
				.nbr           (nbr_ent),
				.cancel_handle (handle),
				.found_in      (fnd[gi]),
				.found_out     (fnd[gi+1]),
				.ent           (ent[gi])
			);
		end
	endgenerate

	stt_proc u_proc (
		.head (ent[0]),
		.step (tick_step_q),
		.fire (h_fire),
		.keep (h_keep),
		.nxt  (h_next)
	);

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		rem_d         = rem_q;
		next_handle_d = next_handle_q;
		pend_valid_d  = pend_valid_q;
		pend_handle_d = pend_handle_q;
		in_ready      = 1'b0;
		cell_op       = C_HOLD;
		ins_en        = 1'b0;
		ins_pos       = cnt_q;
		ins_entry     = '{used: 1'b1, active: 1'b1, rpt: sched_rpt, handle: next_handle_q,
			remaining: delay_clamped, interval: sched_rpt ? delay_clamped : '0};
		out_load      = 1'b0;
		okind_d       = KIND_ACK;
		ohandle_d     = '0;
		olast_d       = 1'b1;

		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_fire) begin
					out_load = 1'b1;
					case (func)
						FUNC_ONCE, FUNC_REPEAT: begin
							if (cnt_q < CNT_W'(SLOTS)) begin
								// append at the first free slot
								ins_en        = 1'b1;
								cnt_d         = cnt_q + 1'b1;
								okind_d       = KIND_SCHED;
								ohandle_d     = next_handle_q;
								next_handle_d = (handle_inc == '0) ? HANDLE_BITS'(1) : handle_inc;
							end else begin
								okind_d = KIND_FULL;
							end
						end
						FUNC_CANCEL: begin
							if (handle != '0) begin
								cell_op = C_CANCEL;
							end
						end
						FUNC_CANCEL_ALL: begin
							cell_op = C_CLEAR;
							cnt_d   = '0;
						end
						FUNC_TICK: begin
							out_load     = 1'b0;
							state_d      = ST_TICK;
							rem_d        = cnt_q;
							pend_valid_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end

			ST_TICK: begin
				if (rem_q != '0) begin
					// Pop the head, push survivors at the end of the occupied run
					if (!(h_fire && pend_valid_q) || out_free) begin
						cell_op   = C_SHIFT;
						ins_en    = h_keep;
						ins_pos   = cnt_q - 1'b1;
						ins_entry = h_next;
						cnt_d     = h_keep ? cnt_q : cnt_q - 1'b1;
						rem_d     = rem_q - 1'b1;
						if (h_fire) begin
							pend_valid_d  = 1'b1;
							pend_handle_d = ent[0].handle;
							if (pend_valid_q) begin
								out_load  = 1'b1;
								okind_d   = KIND_FIRED;
								ohandle_d = pend_handle_q;
								olast_d   = 1'b0;
							end
						end
					end
				end else if (out_free) begin
					// Drain the held fire, or report that nothing fired
					out_load     = 1'b1;
					okind_d      = pend_valid_q ? KIND_FIRED : KIND_ACK;
					ohandle_d    = pend_valid_q ? pend_handle_q : '0;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			rem_q         <= '0;
			next_handle_q <= HANDLE_BITS'(1);
			tick_step_q   <= TIME_W'(1);
			pend_valid_q  <= 1'b0;
			ovalid_q      <= 1'b0;
		end else begin
			state_q       <= state_d;
			cnt_q         <= cnt_d;
			rem_q         <= rem_d;
			next_handle_q <= next_handle_d;
			pend_valid_q  <= pend_valid_d;
			if (cfg_valid && cfg_ready) begin
				tick_step_q <= cfg_data;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold until loaded
	always_ff @(posedge clk) begin
		pend_handle_q <= pend_handle_d;
		if (out_load) begin
			okind_q   <= okind_d;
			ohandle_q <= ohandle_d;
			olast_q   <= olast_d;
		end
	end

endmodule

// ===== sv/stt_checker.sv =====
// Port-level checker for the software timer table, bound to the top level.
// Uses stt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [2:0]                      func,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [1:0]                      kind,
	input logic [stt_pkg::HANDLE_BITS-1:0] timer_handle,
	input logic                            last
);
	import stt_pkg::*;

	logic                   out_stall;
	logic [HANDLE_BITS+2:0] out_word;
	logic                   sched_zero;
	logic                   open_other;
	logic                   quick_req;

	assign out_stall  = out_valid && !out_ready;
	assign out_word   = {kind, timer_handle, last};
	assign sched_zero = out_valid && (kind == KIND_SCHED) && (timer_handle == '0);
	assign open_other = out_valid && (kind != KIND_FIRED) && !last;
	assign quick_req  = in_valid && in_ready && (func != FUNC_TICK);

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

	// A granted handle is never zero
	`ASSERT_ALWAYS(a_sched_handle, !sched_zero, "scheduled with handle zero")

	// Only fired reports may be followed by more results of the same item
	`ASSERT_ALWAYS(a_single_last, !open_other, "non-fire result without last")

	// Every request but a tick answers in the next cycle
	`ASSERT_NEXT(a_quick_answer, quick_req, out_valid && last, "missing single result")

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
